### hdl/gcpb_pkg.sv
// Package for the glyph coverage pixel blender: item structs, format codes
// and configuration register indexes. No dependencies.
`default_nettype none

package gcpb_pkg;

    // Destination pixel formats held in the format register
    typedef enum logic [1:0] {
        FMT_ALPHA8      = 2'd0,
        FMT_RGB565      = 2'd1,
        FMT_ARGB8888    = 2'd2,
        FMT_UNSUPPORTED = 2'd3
    } t_pixel_format;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PIXEL_FORMAT = 1'b0,
        CFG_DRAW_COLOR   = 1'b1
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 32;

    // One input item
    typedef struct packed {
        logic [7:0]  coverage_sample;
        logic [31:0] dest_pixel;
    } t_blend_in;

    // One result item
    typedef struct packed {
        logic [31:0] blended_pixel;
        logic        write_enable;
    } t_blend_out;

endpackage

`default_nettype wire

### hdl/glyph_coverage_pixel_blend.sv
// Top level of the glyph coverage pixel blender: three register stages from
// coverage byte and destination pixel to the blended pixel. Uses gcpb_pkg.
`default_nettype none

// Usage:
//   Input channel: drive i_item with a coverage byte and the destination
//   pixel and raise start; the item is taken at any rising edge where start
//   is high and busy is low. busy stays low, so one item per clock enters.
//   Result channel: o_strobe is high for one cycle with o_result holding the
//   blended pixel and its write enable; the receiver must take it then.
//   Stages: an item taken with start high passes three register stages
//   (coverage weight, channel products, field sums and format select)
//   before its result shows with o_strobe.
//   Throughput: one item per clock.
//   Configuration: i_cfg_we writes register i_cfg_index (0 pixel format,
//   1 draw color) with i_cfg_data at the rising edge. Write only while no
//   item is in flight.
//   Reset (i_rst_n low at a rising edge): format and draw color clear to 0,
//   all stage valid bits clear, in-flight items are dropped.
//   The receiver cannot stall, so the pipeline never holds.
module glyph_coverage_pixel_blend
    import gcpb_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_blend_in             i_item,
    output logic                       o_strobe,
    output t_blend_out                 o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    t_pixel_format r_format;
    logic [31:0]   r_color;

    // Stage 1: weight
    logic        r_s1_valid;
    logic        r_s1_hit;
    logic [7:0]  r_s1_cov;
    logic [31:0] r_s1_dst;
    logic [15:0] n_s1_scaled;

    // Stage 2: products
    logic        r_s2_valid;
    logic        r_s2_hit;
    logic [7:0]  r_s2_cov;
    logic [31:0] r_s2_dst;
    logic [23:0] r_s2_hi_d, r_s2_hi_c;
    logic [18:0] r_s2_mid_d, r_s2_mid_c;
    logic [12:0] r_s2_lo_d, r_s2_lo_c;
    logic [15:0] r_s2_r_d, r_s2_r_c;
    logic [15:0] r_s2_g_d, r_s2_g_c;
    logic [15:0] r_s2_b_d, r_s2_b_c;

    logic [7:0]  w_inv;
    logic [15:0] w_col565;
    logic [15:0] w_dst16;

    // Stage 3: output
    logic        r_out_valid;
    t_blend_out  r_out;
    t_blend_out  n_out;

    logic [23:0] w_sum_hi;
    logic [18:0] w_sum_mid;
    logic [12:0] w_sum_lo;
    logic [8:0]  w_sum_r, w_sum_g, w_sum_b;
    logic [7:0]  w_alpha;
    logic [7:0]  w_min8;

    logic        w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_ALPHA8;
            r_color  <= 32'h0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_FORMAT: r_format <= t_pixel_format'(i_cfg_data[1:0]);
                CFG_DRAW_COLOR:   r_color  <= i_cfg_data[31:0];
                default:          r_color  <= r_color;
            endcase
        end
    end

    // Scale the sample by the color alpha
    assign n_s1_scaled = 16'(r_color[31:24]) * 16'(i_item.coverage_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit <= (i_item.coverage_sample != 8'h00);
        r_s1_cov <= n_s1_scaled[15:8];
        r_s1_dst <= i_item.dest_pixel;
    end

    // Packed 565 copy of the draw color and the complementary weight
    assign w_col565 = {r_color[23:19], r_color[15:10], r_color[7:3]};
    assign w_inv    = 8'hFF - r_s1_cov;
    assign w_dst16  = r_s1_dst[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Form every channel product for both weights
    always_ff @(posedge i_clk) begin
        r_s2_hit   <= r_s1_hit;
        r_s2_cov   <= r_s1_cov;
        r_s2_dst   <= r_s1_dst;
        r_s2_hi_d  <= 24'(w_dst16) * 24'(w_inv);
        r_s2_hi_c  <= 24'(w_col565) * 24'(r_s1_cov);
        r_s2_mid_d <= 19'(w_dst16[10:0]) * 19'(w_inv);
        r_s2_mid_c <= 19'(w_col565[10:0]) * 19'(r_s1_cov);
        r_s2_lo_d  <= 13'(w_dst16[4:0]) * 13'(w_inv);
        r_s2_lo_c  <= 13'(w_col565[4:0]) * 13'(r_s1_cov);
        r_s2_r_d   <= 16'(r_s1_dst[23:16]) * 16'(w_inv);
        r_s2_r_c   <= 16'(r_color[23:16]) * 16'(r_s1_cov);
        r_s2_g_d   <= 16'(r_s1_dst[15:8]) * 16'(w_inv);
        r_s2_g_c   <= 16'(r_color[15:8]) * 16'(r_s1_cov);
        r_s2_b_d   <= 16'(r_s1_dst[7:0]) * 16'(w_inv);
        r_s2_b_c   <= 16'(r_color[7:0]) * 16'(r_s1_cov);
    end

    // Sum the 565 fields; each field keeps only its own bits of the sum
    assign w_sum_hi  = r_s2_hi_d + r_s2_hi_c;
    assign w_sum_mid = r_s2_mid_d + r_s2_mid_c;
    assign w_sum_lo  = r_s2_lo_d + r_s2_lo_c;

    // Truncate each 8888 product to its high byte before adding
    assign w_sum_r = 9'(r_s2_r_d[15:8]) + 9'(r_s2_r_c[15:8]);
    assign w_sum_g = 9'(r_s2_g_d[15:8]) + 9'(r_s2_g_c[15:8]);
    assign w_sum_b = 9'(r_s2_b_d[15:8]) + 9'(r_s2_b_c[15:8]);

    assign w_alpha = (r_s2_cov > r_s2_dst[31:24]) ? r_s2_cov : r_s2_dst[31:24];
    assign w_min8  = (r_s2_cov <= r_s2_dst[7:0]) ? r_s2_cov : r_s2_dst[7:0];

    // Select the result by format; a zero sample echoes the destination
    always_comb begin
        n_out.blended_pixel = r_s2_dst;
        n_out.write_enable  = 1'b0;
        if (r_s2_hit) begin
            case (r_format)
                FMT_ALPHA8: begin
                    n_out.blended_pixel = {24'h0, w_min8};
                    n_out.write_enable  = 1'b1;
                end
                FMT_RGB565: begin
                    n_out.blended_pixel = {16'h0, w_sum_hi[23:19], w_sum_mid[18:13],
                                           w_sum_lo[12:8]};
                    n_out.write_enable  = 1'b1;
                end
                FMT_ARGB8888: begin
                    n_out.blended_pixel = {w_alpha, w_sum_r[7:0], w_sum_g[7:0],
                                           w_sum_b[7:0]};
                    n_out.write_enable  = 1'b1;
                end
                default: begin
                    n_out.blended_pixel = r_s2_dst;
                    n_out.write_enable  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

    // Every accepted item leaves the pipeline as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_strobe)
        else $error("item did not emerge after three stages");

    // No strobe without a matching accepted item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 3))
        else $error("result strobe without a matching item");

    // A skipped pixel echoes its destination value
    a_skip_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.write_enable)
            |-> (o_result.blended_pixel == $past(i_item.dest_pixel, 3)))
        else $error("skipped pixel does not echo destination");

    // No write in the unsupported format
    a_no_write_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.write_enable) |-> (r_format != FMT_UNSUPPORTED))
        else $error("write issued for unsupported format");

    // Alpha8 results stay within one byte
    a_alpha8_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.write_enable && r_format == FMT_ALPHA8)
            |-> (o_result.blended_pixel[31:8] == 24'h0))
        else $error("alpha8 result wider than one byte");

endmodule

`default_nettype wire

### test/glyph_coverage_pixel_blend_tb.sv
// Self-checking testbench for glyph_coverage_pixel_blend: directed and random
// coverage/destination items checked against an in-bench blend predictor.
// Depends on gcpb_pkg and the glyph_coverage_pixel_blend top level.
`timescale 1ns / 1ps

module glyph_coverage_pixel_blend_tb;
    import gcpb_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_blend_in             i_item;
    logic                  o_strobe;
    t_blend_out            o_result;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the block's configuration registers
    t_pixel_format fmt_shadow;
    logic [31:0]   color_shadow;

    // Blended pixels awaited from the block, oldest first
    t_blend_out pending_pixels[$];
    t_blend_out want;

    int n_mismatch  = 0;
    int n_sent      = 0;
    int n_results   = 0;
    int n_written   = 0;
    int n_cfg_write = 0;

    glyph_coverage_pixel_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Log one mismatch, keep the log short
    task automatic report_mismatch(input string what);
        n_mismatch++;
        if (n_mismatch <= 20) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Compute the blended pixel and write enable for one item
    function automatic t_blend_out blended_result(input t_blend_in it);
        logic [31:0] dst;
        logic [31:0] cov;
        logic [31:0] inv;
        logic [31:0] col;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] mid;
        logic [31:0] a;
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        t_blend_out  res;
        dst = it.dest_pixel;
        cov = ({24'd0, color_shadow[31:24]} * {24'd0, it.coverage_sample}) >> 8;
        inv = 32'd255 - cov;
        res.blended_pixel = dst;
        res.write_enable  = 1'b0;
        if (it.coverage_sample != 8'd0) begin
            case (fmt_shadow)
                FMT_ALPHA8: begin
                    // keep the smaller of weight and destination byte
                    res.blended_pixel = (cov <= {24'd0, dst[7:0]}) ? cov : {24'd0, dst[7:0]};
                    res.write_enable  = 1'b1;
                end
                FMT_RGB565: begin
                    dst = dst & 32'hFFFF;
                    col = ((32'd8 * (((color_shadow >> 11) & 32'hFF00)
                          | ((color_shadow >> 8) & 32'hFC)))
                          | ((color_shadow & 32'hFF) >> 3)) & 32'hFFFF;
                    hi  = ((dst * inv + col * cov) >> 8) & 32'hF800;
                    lo  = (((dst & 32'h1F) * inv + (col & 32'h1F) * cov) >> 8) & 32'h1F;
                    mid = (((dst & 32'h7FF) * inv + (col & 32'h7FF) * cov) >> 8) & 32'h7E0;
                    res.blended_pixel = hi | lo | mid;
                    res.write_enable  = 1'b1;
                end
                FMT_ARGB8888: begin
                    // larger alpha wins, red and green use truncating masks
                    a = dst >> 24;
                    if (cov > a) begin
                        a = cov;
                    end
                    r = ((((dst >> 16) & 32'hFF) * inv) & 32'hFFFFFF00)
                      + ((((color_shadow >> 16) & 32'hFF) * cov) & 32'hFFFFFF00);
                    g = ((((dst >> 8) & 32'hFF) * inv) & 32'hFFFFFF00)
                      + ((((color_shadow >> 8) & 32'hFF) * cov) & 32'hFFFFFF00);
                    b = (((dst & 32'hFF) * inv) >> 8)
                      + (((color_shadow & 32'hFF) * cov) >> 8);
                    res.blended_pixel = (r << 8) | g | b | (a << 24);
                    res.write_enable  = 1'b1;
                end
                default: begin
                    res.write_enable = 1'b0;
                end
            endcase
        end
        return res;
    endfunction

    // Hold start until the item is taken, then queue its expected pixel
    task automatic send_item(input logic [7:0] cov_byte, input logic [31:0] dst);
        t_blend_in it;
        it.coverage_sample = cov_byte;
        it.dest_pixel      = dst;
        @(negedge i_clk);
        i_item <= it;
        start  <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_pixels.push_back(blended_result(it));
        n_sent++;
    endtask

    // Drop start for a number of cycles
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Wait until every queued item has come back
    task automatic wait_drained();
        idle_sender(1);
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write one register while the pipeline is empty
    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_PIXEL_FORMAT) begin
            fmt_shadow = t_pixel_format'(val[1:0]);
        end else begin
            color_shadow = val;
        end
        n_cfg_write++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with no item outstanding",
                                          o_result.blended_pixel, o_result.write_enable));
            end else begin
                want = pending_pixels.pop_front();
                n_results++;
                if (want.write_enable) begin
                    n_written++;
                end
                if (o_result.blended_pixel !== want.blended_pixel) begin
                    report_mismatch($sformatf("blended_pixel got %h want %h",
                                              o_result.blended_pixel, want.blended_pixel));
                end
                if (o_result.write_enable !== want.write_enable) begin
                    report_mismatch($sformatf("write_enable got %b want %b",
                                              o_result.write_enable, want.write_enable));
                end
            end
        end
    end

    // Items under the reset configuration: alpha8 with a zero color
    task automatic test_reset_state();
        send_item(8'hFF, 32'hFFFF_FFFF);
        send_item(8'h00, 32'h1234_5678);
        send_item(8'h80, 32'h0000_00FF);
    endtask

    // Field extremes in every format, zero sample, unsupported format, wide destination
    task automatic test_directed_formats();
        t_pixel_format f;
        write_reg(CFG_DRAW_COLOR, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) begin
            f = t_pixel_format'(k);
            write_reg(CFG_PIXEL_FORMAT, {30'd0, f});
            send_item(8'h00, 32'hFFFF_FFFF);
            send_item(8'hFF, 32'h0000_0000);
            send_item(8'hFF, 32'hFFFF_FFFF);
            send_item(8'h80, 32'h5A3C_96E1);
        end
        // wide destination: high bits must be ignored
        write_reg(CFG_DRAW_COLOR, 32'h80C3_5A17);
        write_reg(CFG_PIXEL_FORMAT, {30'd0, FMT_ALPHA8});
        send_item(8'hC8, 32'hFFFF_FF7F);
        write_reg(CFG_PIXEL_FORMAT, {30'd0, FMT_RGB565});
        send_item(8'hFF, 32'hDEAD_BEEF);
        // transparent color in argb8888
        write_reg(CFG_DRAW_COLOR, 32'h0000_0000);
        write_reg(CFG_PIXEL_FORMAT, {30'd0, FMT_ARGB8888});
        send_item(8'hFF, 32'h80FF_00FF);
    endtask

    // Random settings and items, the sender idling with chance idle_pct in a hundred
    task automatic test_random_blend(input int n_items, input int idle_pct);
        int          left;
        int          seg;
        logic [7:0]  cov_byte;
        logic [31:0] dst;
        logic [31:0] color;
        left = n_items;
        while (left > 0) begin
            // pick a new setting, extremes included
            case ($urandom_range(0, 3))
                0:       color = 32'h0000_0000;
                1:       color = 32'hFFFF_FFFF;
                2:       color = {8'hFF, 24'($urandom)};
                default: color = $urandom;
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_DRAW_COLOR, color);
                write_reg(CFG_PIXEL_FORMAT, {30'd0, 2'($urandom_range(0, 3))});
            end else begin
                write_reg(CFG_PIXEL_FORMAT, {30'd0, 2'($urandom_range(0, 3))});
                write_reg(CFG_DRAW_COLOR, color);
            end
            seg = $urandom_range(20, 80);
            if (seg > left) begin
                seg = left;
            end
            for (int k = 0; k < seg; k++) begin
                case ($urandom_range(0, 9))
                    0:       cov_byte = 8'h00;
                    1:       cov_byte = 8'hFF;
                    2:       cov_byte = 8'h01;
                    default: cov_byte = 8'($urandom);
                endcase
                dst = $urandom;
                case ($urandom_range(0, 9))
                    0: dst = 32'h0000_0000;
                    1: dst = 32'hFFFF_FFFF;
                    2, 3, 4: begin
                        // zero-extended destination of the current width
                        if (fmt_shadow == FMT_ALPHA8) begin
                            dst = {24'd0, dst[7:0]};
                        end else if (fmt_shadow == FMT_RGB565) begin
                            dst = {16'd0, dst[15:0]};
                        end
                    end
                    default: ;
                endcase
                send_item(cov_byte, dst);
                // idle each following cycle with probability idle_pct in a hundred
                while ($urandom_range(0, 99) < idle_pct) begin
                    idle_sender(1);
                end
            end
            left -= seg;
        end
    endtask

    // Run timeout
    initial begin
        #2_000_000;
        $display("glyph_coverage_pixel_blend_tb failed");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        fmt_shadow   = FMT_ALPHA8;
        color_shadow = 32'd0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_formats();
        test_random_blend(600, 12);
        test_random_blend(600, 60);
        test_random_blend(600, 0);

        // drain, then allow for the pipeline depth
        idle_sender(1);
        for (int k = 0; k < 200 && pending_pixels.size() != 0; k++) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d items never returned a result",
                                      pending_pixels.size()));
        end

        $display("Covered %0d items in all four formats over %0d register writes",
                 n_sent, n_cfg_write);
        $display("Checked %0d results: %0d written back, %0d skipped, %0d mismatches",
                 n_results, n_written, n_results - n_written, n_mismatch);
        if (n_mismatch == 0) begin
            $display("glyph_coverage_pixel_blend_tb passed");
        end else begin
            $display("glyph_coverage_pixel_blend_tb failed");
        end
        $finish;
    end

endmodule

### files.f
hdl/gcpb_pkg.sv
hdl/glyph_coverage_pixel_blend.sv
test/glyph_coverage_pixel_blend_tb.sv
